// ===== design/shcf_pkg.sv =====
// Shared types and constants for the sync header command frame parser.
// No dependencies; imported by every module of the block.
package shcf_pkg;

  localparam logic [7:0] SYNC_FIRST  = 8'h55;
  localparam logic [7:0] SYNC_SECOND = 8'hAA;
  localparam logic [7:0] CMD_LEVEL   = 8'h03;
  localparam logic [7:0] CMD_SWITCH  = 8'h01;
  localparam logic [7:0] LEVEL_MAX   = 8'd100;
  localparam logic [7:0] SWITCH_MAX  = 8'd1;
  localparam int         FRAME_LEN   = 5;

  // Frame queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_UNKNOWN   = 2'd1,
    ST_RANGE     = 2'd2,
    ST_CHECK_BAD = 2'd3
  } status_t;

  // Phase of a frame after its header pair has been seen.
  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_VAL = 2'd1,
    PH_CHK = 2'd2
  } phase_t;

  typedef struct packed {
    logic [7:0] cmd;
    logic [7:0] val;
    logic [7:0] chk;
  } frame_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_sts_t;

endpackage

// ===== design/shcf_front.sv =====
// Front part: accepts received bytes, tracks the byte window count and the
// header search, and emits complete frames. Depends on shcf_pkg.
module shcf_front
  import shcf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output frame_t     frame
);

  localparam int CW = $clog2(WINDOW_DEPTH);

  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  phase_t        phase_r, phase_nxt;
  logic [7:0]    last_r, cmd_r, cmd_nxt, val_r, val_nxt;

  logic          wrap;
  logic [CW-1:0] idx;
  logic [CW-1:0] ncnt;
  logic          found_cur;
  logic          pair_new;
  logic          found_new;
  logic          frame_done;

  always_comb begin
    wrap      = (cnt_r >= CW'(WINDOW_DEPTH - 1));
    idx       = wrap ? '0 : cnt_r;
    ncnt      = idx + CW'(1);
    // A restart drops the old window, so any header seen in it is gone.
    found_cur = found_r && !wrap;
    pair_new  = !found_cur && (idx != '0) && (last_r == SYNC_FIRST) &&
                (rx_byte == SYNC_SECOND);
    found_new = found_cur || pair_new;
    frame_done = found_cur && (phase_r == PH_CHK);

    cnt_nxt   = cnt_r;
    found_nxt = found_r;
    phase_nxt = phase_r;
    cmd_nxt   = cmd_r;
    val_nxt   = val_r;

    if (accept) begin
      if (pair_new) begin
        phase_nxt = PH_CMD;
      end else if (found_cur) begin
        unique case (phase_r)
          PH_CMD: begin
            cmd_nxt   = rx_byte;
            phase_nxt = PH_VAL;
          end
          PH_VAL: begin
            val_nxt   = rx_byte;
            phase_nxt = PH_CHK;
          end
          default: phase_nxt = PH_CMD;
        endcase
      end

      if (frame_done) begin
        // The frame always ends exactly at the last held byte.
        cnt_nxt   = '0;
        found_nxt = 1'b0;
      end else if ((ncnt >= CW'(FRAME_LEN)) && !found_new) begin
        cnt_nxt   = '0;
        found_nxt = 1'b0;
      end else begin
        cnt_nxt   = ncnt;
        found_nxt = found_new;
      end
    end
  end

  assign push      = accept && frame_done;
  assign frame.cmd = cmd_r;
  assign frame.val = val_r;
  assign frame.chk = rx_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      found_r <= 1'b0;
      phase_r <= PH_CMD;
    end else begin
      cnt_r   <= cnt_nxt;
      found_r <= found_nxt;
      phase_r <= phase_nxt;
    end
    if (accept) begin
      last_r <= rx_byte;
    end
    cmd_r <= cmd_nxt;
    val_r <= val_nxt;
  end

endmodule

// ===== design/shcf_queue.sv =====
// Two-entry frame queue that decouples the front part from the back part.
// Depends on shcf_pkg.
module shcf_queue
  import shcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  queue_ctl_t ctl,
  input  frame_t     wr_data,
  output frame_t     rd_data,
  output queue_sts_t sts
);

  frame_t            mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;

  assign sts.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign sts.empty = (cnt_r == '0);
  assign rd_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (ctl.push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (ctl.pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({ctl.push, ctl.pop})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (ctl.push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

// ===== design/shcf_back.sv =====
// Back part: checks one queued frame and holds the result in the output
// register until it is taken. Depends on shcf_pkg.
module shcf_back
  import shcf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  frame_t     q_data,
  output logic       q_pop,
  input  logic       out_stall,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [7:0] out_command,
  output logic [7:0] out_payload,
  output logic [7:0] out_expected_check
);

  logic       valid_r;
  status_t    status_r, status_nxt;
  logic [7:0] cmd_r, val_r, exp_r, exp_nxt;

  assign q_pop = !q_empty && (!valid_r || !out_stall);

  always_comb begin
    exp_nxt = SYNC_FIRST ^ SYNC_SECOND ^ q_data.cmd ^ q_data.val;
    priority if ((q_data.cmd != CMD_LEVEL) && (q_data.cmd != CMD_SWITCH)) begin
      status_nxt = ST_UNKNOWN;
    end else if (((q_data.cmd == CMD_LEVEL) && (q_data.val > LEVEL_MAX)) ||
                 ((q_data.cmd == CMD_SWITCH) && (q_data.val > SWITCH_MAX))) begin
      status_nxt = ST_RANGE;
    end else if (q_data.chk != exp_nxt) begin
      status_nxt = ST_CHECK_BAD;
    end else begin
      status_nxt = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (q_pop) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
    if (q_pop) begin
      status_r <= status_nxt;
      cmd_r    <= q_data.cmd;
      val_r    <= q_data.val;
      exp_r    <= exp_nxt;
    end
  end

  assign out_valid          = valid_r;
  assign out_status         = status_r;
  assign out_command        = cmd_r;
  assign out_payload        = val_r;
  assign out_expected_check = exp_r;

endmodule

// ===== design/sync_header_command_frame_parser.sv =====
// Sync header command frame parser: one received byte accepted per cycle.
// A frame result is written to the frame queue at the edge that accepts its
// check byte and moves to the output register when the back part pops it;
// throughput is one byte per cycle, held off only when the two-entry frame
// queue is full. Synchronous active-low reset empties the window count, the
// queue and the output register; no clearing pass is needed.
module sync_header_command_frame_parser
  import shcf_pkg::*;
#(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] out_status,
  output logic [7:0] out_command,
  output logic [7:0] out_payload,
  output logic [7:0] out_expected_check
);

  logic       accept;
  logic       push;
  logic       pop;
  frame_t     fr_in;
  frame_t     fr_out;
  queue_ctl_t q_ctl;
  queue_sts_t q_sts;

  // A frame can complete on any byte, so bytes wait while the queue is full.
  assign in_stall  = q_sts.full;
  assign accept    = in_valid && !in_stall;
  assign q_ctl.push = push;
  assign q_ctl.pop  = pop;

  shcf_front #(
    .WINDOW_DEPTH(WINDOW_DEPTH)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .rx_byte(in_rx_byte),
    .push   (push),
    .frame  (fr_in)
  );

  shcf_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (q_ctl),
    .wr_data(fr_in),
    .rd_data(fr_out),
    .sts    (q_sts)
  );

  shcf_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .q_empty           (q_sts.empty),
    .q_data            (fr_out),
    .q_pop             (pop),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .out_status        (out_status),
    .out_command       (out_command),
    .out_payload       (out_payload),
    .out_expected_check(out_expected_check)
  );

endmodule

// ===== tb/testbench.sv =====
// Self-checking testbench for the sync header command frame parser.
// Feeds received bytes, predicts every reported frame and compares field by field.
// Depends on shcf_pkg and the sync_header_command_frame_parser module.
module testbench
  import shcf_pkg::*;
();

  localparam int WIN_DEPTH      = 8;
  localparam int TARGET_BYTES   = 1950;
  localparam int LONG_HOLD      = 150;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int END_WAIT       = 10;

  typedef struct packed {
    status_t    status;
    logic [7:0] command;
    logic [7:0] payload;
    logic [7:0] check;
  } frame_result_t;

  class frame_scoreboard;
    logic [7:0]    window [WIN_DEPTH];
    int unsigned   held;
    frame_result_t expected_frames [$];
    int            errors;
    int            frames_seen;
    int            status_seen [4];

    function new();
      held = 0;
      errors = 0;
      frames_seen = 0;
      foreach (status_seen[i]) status_seen[i] = 0;
    endfunction

    function int pending();
      return expected_frames.size();
    endfunction

    function status_t classify(logic [7:0] cmd, logic [7:0] val, logic [7:0] chk,
                               logic [7:0] xsum);
      if (cmd != CMD_LEVEL && cmd != CMD_SWITCH) return ST_UNKNOWN;
      if (cmd == CMD_LEVEL && val > LEVEL_MAX) return ST_RANGE;
      if (cmd == CMD_SWITCH && val > SWITCH_MAX) return ST_RANGE;
      if (chk != xsum) return ST_CHECK_BAD;
      return ST_OK;
    endfunction

    // Updates the byte window for one accepted item and queues a frame if one completes.
    function void take_byte(logic [7:0] b);
      int            cnt;
      int            h;
      int            used;
      bit            found;
      frame_result_t r;
      cnt = held;
      // A nearly full window starts over with the new byte.
      if (cnt >= WIN_DEPTH - 1) cnt = 0;
      window[cnt] = b;
      cnt++;
      held = cnt;
      if (cnt < FRAME_LEN) return;
      found = 1'b0;
      for (h = 0; h + 1 < cnt; h++) begin
        if (window[h] == SYNC_FIRST && window[h + 1] == SYNC_SECOND) begin
          found = 1'b1;
          break;
        end
      end
      if (!found) begin
        held = 0;
        return;
      end
      if (cnt < h + FRAME_LEN) return;
      r.command = window[h + 2];
      r.payload = window[h + 3];
      r.check   = SYNC_FIRST ^ SYNC_SECOND ^ r.command ^ r.payload;
      r.status  = classify(r.command, r.payload, window[h + 4], r.check);
      expected_frames.push_back(r);
      used = h + FRAME_LEN;
      for (int i = 0; i < cnt - used; i++) window[i] = window[i + used];
      held = cnt - used;
    endfunction

    function void report(string field, int exp_val, int act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, exp_val,
               act_val);
    endfunction

    function void check_frame(logic [1:0] st, logic [7:0] cmd, logic [7:0] pay,
                              logic [7:0] chk);
      frame_result_t r;
      if (expected_frames.size() == 0) begin
        errors++;
        $display("%0t: unexpected frame, expected none, actual status %0d command %0d",
                 $time, st, cmd);
        return;
      end
      r = expected_frames.pop_front();
      frames_seen++;
      status_seen[r.status]++;
      if (st != r.status) report("status", r.status, st);
      if (cmd != r.command) report("command", r.command, cmd);
      if (pay != r.payload) report("payload", r.payload, pay);
      if (chk != r.check) report("expected_check", r.check, chk);
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_command;
  logic [7:0] out_payload;
  logic [7:0] out_expected_check;

  frame_scoreboard sb = new();
  bit no_idle = 1'b0;
  bit hold_off_req = 1'b0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  sync_header_command_frame_parser #(.WINDOW_DEPTH(WIN_DEPTH)) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_command(out_command),
    .out_payload(out_payload),
    .out_expected_check(out_expected_check)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) sb.take_byte(in_rx_byte);
      if (out_valid && !out_stall)
        sb.check_frame(out_status, out_command, out_payload, out_expected_check);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Timeout after %0d cycles without an accepted item", WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result side: a random stall before each item (none while no_idle is set), or a long one when requested.
  initial begin
    int n;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_off_req) begin
        n = LONG_HOLD;
        hold_off_req = 1'b0;
      end else begin
        n = no_idle ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  function automatic logic [7:0] frame_xor(logic [7:0] cmd, logic [7:0] val);
    return SYNC_FIRST ^ SYNC_SECOND ^ cmd ^ val;
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [7:0] val,
                            input logic [7:0] chk);
    send_byte(SYNC_FIRST);
    send_byte(SYNC_SECOND);
    send_byte(cmd);
    send_byte(val);
    send_byte(chk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_noise(input int count);
    int pick;
    repeat (count) begin
      pick = $urandom_range(0, 99);
      // Stray sync bytes make partial and overlapping headers.
      if (pick < 20) send_byte(SYNC_FIRST);
      else if (pick < 30) send_byte(SYNC_SECOND);
      else send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int         pick;
    logic [7:0] cmd;
    logic [7:0] val;
    logic [7:0] chk;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part.
    send_frame(CMD_LEVEL, LEVEL_MAX, frame_xor(CMD_LEVEL, LEVEL_MAX));
    send_frame(8'h00, 8'hFF, 8'h00);
    send_frame(CMD_SWITCH, 8'd2, frame_xor(CMD_SWITCH, 8'd2));
    send_frame(CMD_SWITCH, 8'd0, 8'hFF);
    // Five bytes without a header pair are dropped.
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h00);
    // A header too late in the window is lost when the window starts over.
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h56);
    send_frame(CMD_LEVEL, 8'd0, frame_xor(CMD_LEVEL, 8'd0));
    send_byte(8'hFF);
    send_frame(CMD_SWITCH, 8'd1, frame_xor(CMD_SWITCH, 8'd1));
    drain();

    // Long stall on the result side while bytes keep coming back to back.
    no_idle = 1'b1;
    hold_off_req = 1'b1;
    repeat (12) send_frame(CMD_LEVEL, 8'd50, frame_xor(CMD_LEVEL, 8'd50));
    no_idle = 1'b0;
    drain();

    // Random part: mostly well-formed frames, some noise and cut-off frames.
    while (bytes_sent < TARGET_BYTES) begin
      if ($urandom_range(0, 99) < 4) no_idle = ~no_idle;
      if ($urandom_range(0, 99) < 2) drain();
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_noise($urandom_range(0, 2));
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
          cmd = CMD_LEVEL;
          val = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 100))
                                             : 8'($urandom_range(0, 255));
        end else if (pick < 80) begin
          cmd = CMD_SWITCH;
          val = ($urandom_range(0, 3) != 0) ? 8'($urandom_range(0, 1))
                                             : 8'($urandom_range(0, 255));
        end else begin
          cmd = 8'($urandom_range(0, 255));
          val = 8'($urandom_range(0, 255));
        end
        chk = ($urandom_range(0, 99) < 80) ? frame_xor(cmd, val) : 8'($urandom_range(0, 255));
        send_frame(cmd, val, chk);
      end else if (pick < 85) begin
        send_noise($urandom_range(1, 8));
      end else begin
        send_byte(SYNC_FIRST);
        send_byte(SYNC_SECOND);
        send_noise($urandom_range(0, 2));
      end
    end

    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    $display("Sent %0d bytes including noise, cut-off frames and window restarts.",
             bytes_sent);
    $display("Checked %0d frames: %0d ok, %0d unknown command, %0d out of range, %0d bad check.",
             sb.frames_seen, sb.status_seen[ST_OK], sb.status_seen[ST_UNKNOWN],
             sb.status_seen[ST_RANGE], sb.status_seen[ST_CHECK_BAD]);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== files.f =====
design/shcf_pkg.sv
design/shcf_front.sv
design/shcf_queue.sv
design/shcf_back.sv
design/sync_header_command_frame_parser.sv
tb/testbench.sv
